@@ sv/eae_pkg.sv @@
// ----------------------------------------------------------------------------
// eae_pkg - shared constants, types and tables for the exponential ADSR block
// Stage and mode codes, register indexes, fixed-point constants and the log2
// fraction table built at elaboration by repeated squaring.
// ----------------------------------------------------------------------------
`default_nettype none

package eae_pkg;

  // counter and table sizing
  localparam int COUNT_BITS        = 24;
  localparam int CNT_W             = COUNT_BITS;
  localparam int LOG_TABLE_ENTRIES = 256;
  localparam int LOG_IDX_W         = $clog2(LOG_TABLE_ENTRIES);

  // field widths
  localparam int MODE_W  = 2;
  localparam int LEVEL_W = 16;
  localparam int STAGE_W = 3;
  localparam int PADDR_W = 5;

  // divider sizing: numerator |ln| + 2*len, denominator 4*len
  localparam int NUM_W = 37;
  localparam int DEN_W = CNT_W + 2;

  // Q2.30 unity and ln2 in Q16
  localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
  localparam logic [15:0] LN2_Q16   = 16'd45426;
  localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

  // stage codes
  localparam logic [STAGE_W-1:0] ST_OFF     = 3'd0;
  localparam logic [STAGE_W-1:0] ST_ATTACK  = 3'd1;
  localparam logic [STAGE_W-1:0] ST_DECAY   = 3'd2;
  localparam logic [STAGE_W-1:0] ST_SUSTAIN = 3'd3;
  localparam logic [STAGE_W-1:0] ST_RELEASE = 3'd4;

  // command modes
  localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NOTE_ON = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

  // register indexes
  localparam logic [2:0] REG_ATTACK_SAMPLES  = 3'd0;
  localparam logic [2:0] REG_DECAY_SAMPLES   = 3'd1;
  localparam logic [2:0] REG_RELEASE_SAMPLES = 3'd2;
  localparam logic [2:0] REG_ATTACK_LEVEL    = 3'd3;
  localparam logic [2:0] REG_SUSTAIN_LEVEL   = 3'd4;
  localparam logic [2:0] REG_MIN_LEVEL       = 3'd5;
  localparam logic [2:0] REG_VELOCITY_SENSE  = 3'd6;

  typedef logic [15:0] log_tab_t [LOG_TABLE_ENTRIES];

  // log2(1 + i/N) in Q0.16, truncated, one bit per squaring
  function automatic log_tab_t build_log_tab();
    log_tab_t    t;
    logic [63:0] y;
    logic [15:0] r;
    for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
      y = 64'(ONE_Q30) + ((64'(i) << 30) / LOG_TABLE_ENTRIES);
      r = '0;
      for (int b = 0; b < 16; b++) begin
        y = (y * y) >> 30;
        r = r << 1;
        if (y >= (64'(ONE_Q30) << 1)) begin
          y = y >> 1;
          r = r | 16'd1;
        end
      end
      t[i] = r;
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

  // table index from a normalised mantissa (bit 15 set)
  function automatic logic [LOG_IDX_W-1:0] log_index(logic [15:0] m);
    logic [31:0] p;
    p = (32'(m[14:0]) * 32'(LOG_TABLE_ENTRIES)) >> 15;
    if (p >= 32'(LOG_TABLE_ENTRIES)) p = 32'(LOG_TABLE_ENTRIES - 1);
    return p[LOG_IDX_W-1:0];
  endfunction

  // stage length, saturated to the counter range
  function automatic logic [CNT_W-1:0] clip_len(logic [23:0] v);
    logic [31:0] v32;
    v32 = {8'd0, v};
    if (v32 > COUNT_MAX) return COUNT_MAX[CNT_W-1:0];
    return v32[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/eae_stream_if.sv @@
// ----------------------------------------------------------------------------
// eae_stream_if - valid/ready channels of the envelope block
// Command channel (mode, velocity) and result channel (level, stage).
// ----------------------------------------------------------------------------
`default_nettype none

interface eae_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [eae_pkg::MODE_W-1:0]   mode;
  logic [eae_pkg::LEVEL_W-1:0]  velocity;

  modport source (output valid, mode, velocity, input ready);
  modport sink   (input valid, mode, velocity, output ready);
endinterface

interface eae_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [eae_pkg::LEVEL_W-1:0]  level;
  logic [eae_pkg::STAGE_W-1:0]  stage;

  modport source (output valid, level, stage, input ready);
  modport sink   (input valid, level, stage, output ready);
endinterface

`default_nettype wire

@@ sv/exponential_adsr_envelope.sv @@
// ----------------------------------------------------------------------------
// exponential_adsr_envelope - exponential ADSR envelope generator
// Command words: tick, note on, note release. One result word per tick.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one word per command; mode 0 is a sample tick, 1 note on,
//   2 note release, 3 is ignored. Only ticks give a result word on rsp.
//   Registers are to be written over the APB port only while the block
//   is idle; the block itself does not enforce this. One command is
//   worked on at a time; cmd.ready is high only when idle.
//   Tick within a stage: two passes of the bit-serial multiplier (level
//   update, then velocity scaling). Tick in sustain: scaling pass only.
//   Tick when off: no multiplier pass; the result word appears in the
//   cycle the block is ready again. Entering a timed stage adds two
//   serial log2 passes and the serial divider.
//   Note on / release: no result word.
//   A finished result waits in the rsp register; while rsp is stalled the
//   next tick finishes its work and holds until the register frees up.
//   Reset (synchronous, active high) restores the register defaults and
//   puts the envelope in the off stage at level zero.
// ----------------------------------------------------------------------------
`default_nettype none

module exponential_adsr_envelope (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [eae_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  eae_cmd_if.sink                     cmd,
  eae_rsp_if.source                   rsp
);
  import eae_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_ENTER     = 4'd1;
  localparam logic [3:0] S_LOG_END   = 4'd2;
  localparam logic [3:0] S_LOG_START = 4'd3;
  localparam logic [3:0] S_DIV       = 4'd4;
  localparam logic [3:0] S_UPD       = 4'd5;
  localparam logic [3:0] S_SCALE     = 4'd6;
  localparam logic [3:0] S_EMIT      = 4'd7;

  // configuration registers
  logic [23:0] attack_samples;
  logic [23:0] decay_samples;
  logic [23:0] release_samples;
  logic [15:0] attack_level;
  logic [15:0] sustain_level;
  logic [15:0] min_level;
  logic [15:0] velocity_sense;

  // envelope state
  logic [3:0]         state;
  logic               kick;
  logic               from_tick;
  logic [STAGE_W-1:0] tgt;
  logic [STAGE_W-1:0] stage_now;
  logic [31:0]        level_now;
  logic [31:0]        multiplier;
  logic [CNT_W-1:0]   sample_count;
  logic [CNT_W-1:0]   stage_length;
  logic [31:0]        scale;
  logic [15:0]        st_start;
  logic [15:0]        st_end;
  logic [19:0]        log_end;
  logic [35:0]        mag;
  logic               neg;
  logic [15:0]        emit_level;
  logic               rsp_valid;
  logic [15:0]        rsp_level;
  logic [STAGE_W-1:0] rsp_stage;

  // unit connections
  logic        mul_done;
  logic [63:0] mul_prod;
  logic        div_done;
  logic [NUM_W-1:0] div_quo;
  logic        log_done;
  logic [19:0] log_res;

  // ---------------- APB register port ----------------
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_samples  <= 24'd480;
      decay_samples   <= 24'd4800;
      release_samples <= 24'd4800;
      attack_level    <= 16'd32768;
      sustain_level   <= 16'd16384;
      min_level       <= 16'd33;
      velocity_sense  <= 16'd0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ATTACK_SAMPLES:  attack_samples  <= pwdata[23:0];
        REG_DECAY_SAMPLES:   decay_samples   <= pwdata[23:0];
        REG_RELEASE_SAMPLES: release_samples <= pwdata[23:0];
        REG_ATTACK_LEVEL:    attack_level    <= pwdata[15:0];
        REG_SUSTAIN_LEVEL:   sustain_level   <= pwdata[15:0];
        REG_MIN_LEVEL:       min_level       <= pwdata[15:0];
        REG_VELOCITY_SENSE:  velocity_sense  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ATTACK_SAMPLES:  prdata = {8'd0, attack_samples};
      REG_DECAY_SAMPLES:   prdata = {8'd0, decay_samples};
      REG_RELEASE_SAMPLES: prdata = {8'd0, release_samples};
      REG_ATTACK_LEVEL:    prdata = {16'd0, attack_level};
      REG_SUSTAIN_LEVEL:   prdata = {16'd0, sustain_level};
      REG_MIN_LEVEL:       prdata = {16'd0, min_level};
      REG_VELOCITY_SENSE:  prdata = {16'd0, velocity_sense};
      default:             prdata = 32'd0;
    endcase
  end

  // ---------------- stage entry values ----------------
  logic [15:0]      mn;
  logic [16:0]      cur17;
  logic [15:0]      cur16;
  logic [CNT_W-1:0] e_len;
  logic [15:0]      e_start;
  logic [15:0]      e_end;
  logic [31:0]      e_level;
  logic             timed;

  assign mn    = (min_level == 16'd0) ? 16'd1 : min_level;
  assign cur17 = level_now[31:15];
  assign cur16 = cur17[16] ? 16'hFFFF : cur17[15:0];
  assign timed = tgt inside {ST_ATTACK, ST_DECAY, ST_RELEASE};

  always_comb begin
    e_len   = stage_length;
    e_start = mn;
    e_end   = mn;
    e_level = level_now;
    case (tgt)
      ST_ATTACK: begin
        e_len   = clip_len(attack_samples);
        e_end   = (attack_level == 16'd0) ? 16'd1 : attack_level;
        e_level = {1'b0, mn, 15'd0};
      end
      ST_DECAY: begin
        e_len   = clip_len(decay_samples);
        e_start = (attack_level < mn) ? mn : attack_level;
        e_end   = (sustain_level > mn) ? sustain_level : mn;
        e_level = {1'b0, e_start, 15'd0};
      end
      ST_SUSTAIN: e_level = {1'b0, sustain_level, 15'd0};
      ST_RELEASE: begin
        e_len = clip_len(release_samples);
        // start below the floor: clamp to the floor
        if (cur16 < mn) begin
          e_start = mn;
          e_level = {1'b0, mn, 15'd0};
        end else begin
          e_start = cur16;
        end
      end
      default: e_level = 32'd0;
    endcase
  end

  // ---------------- arithmetic around the units ----------------
  logic [20:0]      d_diff;
  logic [19:0]      abs_d;
  logic [35:0]      mag_calc;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [37:0]      up_sum;
  logic [31:0]      mult_calc;
  logic [35:0]      upd_round;
  logic [31:0]      upd_level;
  logic [18:0]      out_lv;
  logic [31:0]      vv;
  logic signed [34:0] vbase;
  logic signed [34:0] vsum;
  logic [31:0]      scale_calc;
  logic [15:0]      off_level;
  logic [STAGE_W-1:0] stage_after;

  // log difference times ln2
  assign d_diff   = {1'b0, log_end} - {1'b0, log_res};
  assign abs_d    = d_diff[20] ? 20'(-d_diff) : d_diff[19:0];
  assign mag_calc = 36'(abs_d) * 36'(LN2_Q16);

  // rounded |ln| / (4 * length)
  assign div_num = NUM_W'(mag) + (NUM_W'(stage_length) << 1);
  assign div_den = {stage_length, 2'b00};

  assign up_sum = 38'(div_quo) + 38'(ONE_Q30);
  always_comb begin
    if (neg) begin
      mult_calc = (div_quo >= NUM_W'(ONE_Q30)) ? 32'd0 : ONE_Q30 - div_quo[31:0];
    end else begin
      mult_calc = (up_sum > 38'hFFFF_FFFF) ? 32'hFFFF_FFFF : up_sum[31:0];
    end
  end

  // level * multiplier, rounded and saturated
  assign upd_round = {1'b0, mul_prod[63:29]} + 36'd1;
  assign upd_level = (upd_round[35:33] != 3'd0) ? 32'hFFFF_FFFF : upd_round[32:1];

  assign out_lv = mul_prod[63:45];

  // velocity scale, floored at zero
  assign vv         = 32'(velocity_sense) * 32'(cmd.velocity);
  assign vbase      = (35'sd32768 - $signed({19'd0, velocity_sense})) <<< 15;
  assign vsum       = $signed({3'd0, vv}) + vbase;
  assign scale_calc = vsum[34] ? 32'd0 : vsum[31:0];

  assign off_level = (cur17 > 17'd32768) ? 16'd32768 : cur17[15:0];

  always_comb begin
    case (stage_now)
      ST_ATTACK: stage_after = ST_DECAY;
      ST_DECAY:  stage_after = ST_SUSTAIN;
      default:   stage_after = ST_OFF;
    endcase
  end

  // ---------------- serial units ----------------
  eae_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (kick && (state == S_UPD || state == S_SCALE)),
    .a     (level_now),
    .b     ((state == S_SCALE) ? scale : multiplier),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  eae_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (kick && state == S_DIV),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  eae_log2 u_log (
    .clk   (clk),
    .rst   (rst),
    .start (kick && (state == S_LOG_END || state == S_LOG_START)),
    .x     ((state == S_LOG_END) ? st_end : st_start),
    .done  (log_done),
    .res   (log_res)
  );

  // ---------------- sequencer ----------------
  logic rsp_free;

  assign cmd.ready = (state == S_IDLE);
  assign rsp_free  = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      kick         <= 1'b0;
      from_tick    <= 1'b0;
      stage_now    <= ST_OFF;
      level_now    <= 32'd0;
      multiplier   <= ONE_Q30;
      sample_count <= '0;
      stage_length <= '0;
    end else begin
      kick <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            case (cmd.mode)
              MODE_NOTE_ON: begin
                tgt       <= ST_ATTACK;
                from_tick <= 1'b0;
                state     <= S_ENTER;
              end
              MODE_RELEASE: begin
                tgt       <= ST_RELEASE;
                from_tick <= 1'b0;
                state     <= S_ENTER;
              end
              MODE_TICK: begin
                scale <= scale_calc;
                if (stage_now == ST_OFF) begin
                  emit_level <= off_level;
                  state      <= S_EMIT;
                end else if (stage_now == ST_SUSTAIN) begin
                  kick  <= 1'b1;
                  state <= S_SCALE;
                end else if (sample_count >= stage_length) begin
                  tgt       <= stage_after;
                  from_tick <= 1'b1;
                  state     <= S_ENTER;
                end else begin
                  kick  <= 1'b1;
                  state <= S_UPD;
                end
              end
              default: ;
            endcase
          end
        end
        S_ENTER: begin
          stage_now    <= tgt;
          sample_count <= '0;
          level_now    <= e_level;
          stage_length <= e_len;
          st_start     <= e_start;
          st_end       <= e_end;
          if (timed && e_len != '0) begin
            kick  <= 1'b1;
            state <= S_LOG_END;
          end else begin
            multiplier <= ONE_Q30;
            kick       <= from_tick;
            state      <= from_tick ? S_UPD : S_IDLE;
          end
        end
        S_LOG_END: begin
          if (log_done) begin
            log_end <= log_res;
            kick    <= 1'b1;
            state   <= S_LOG_START;
          end
        end
        S_LOG_START: begin
          if (log_done) begin
            neg   <= d_diff[20];
            mag   <= mag_calc;
            kick  <= 1'b1;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            multiplier <= mult_calc;
            kick       <= from_tick;
            state      <= from_tick ? S_UPD : S_IDLE;
          end
        end
        S_UPD: begin
          if (mul_done) begin
            level_now    <= upd_level;
            sample_count <= sample_count + 1'b1;
            kick         <= 1'b1;
            state        <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (mul_done) begin
            emit_level <= (out_lv > 19'd32768) ? 16'd32768 : out_lv[15:0];
            state      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (rsp_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_EMIT && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && rsp_free) begin
      rsp_level <= emit_level;
      rsp_stage <= stage_now;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.level = rsp_level;
  assign rsp.stage = rsp_stage;

endmodule

`default_nettype wire

@@ sv/eae_mul.sv @@
// ----------------------------------------------------------------------------
// eae_mul - bit-serial 32 x 32 unsigned multiplier
// Shift-add, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module eae_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [63:0] prod
);
  import eae_pkg::*;

  logic [31:0] areg;
  logic [31:0] hi;
  logic [31:0] lo;
  logic [4:0]  cnt;
  logic        busy;
  logic [32:0] sum;

  // partial sum for this bit
  assign sum  = {1'b0, hi} + (lo[0] ? {1'b0, areg} : 33'd0);
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        areg <= a;
        hi   <= '0;
        lo   <= b;
      end else if (busy) begin
        hi  <= sum[32:1];
        lo  <= {sum[0], lo[31:1]};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/eae_div.sv @@
// ----------------------------------------------------------------------------
// eae_div - bit-serial restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module eae_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [eae_pkg::NUM_W-1:0] num,
  input  logic [eae_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [eae_pkg::NUM_W-1:0] quo
);
  import eae_pkg::*;

  logic [DEN_W-1:0] dreg;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] qr;
  logic [5:0]       cnt;
  logic             busy;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  // trial subtract
  assign rem_sh = {rem, qr[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, dreg};
  assign ge     = rem_sh >= {1'b0, dreg};
  assign quo    = qr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dreg <= den;
        rem  <= '0;
        qr   <= num;
      end else if (busy) begin
        rem <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        qr  <= {qr[NUM_W-2:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/eae_log2.sv @@
// ----------------------------------------------------------------------------
// eae_log2 - serial log2 of a 16-bit level, result in Q4.16
// Normalises by one left shift per cycle, then adds the fraction table entry.
// ----------------------------------------------------------------------------
`default_nettype none

module eae_log2 (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] x,
  output logic        done,
  output logic [19:0] res
);
  import eae_pkg::*;

  logic [15:0] m;
  logic [3:0]  e;
  logic        busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        m    <= (x == 16'd0) ? 16'd1 : x;
        e    <= 4'd15;
      end else if (busy) begin
        if (m[15]) begin
          // normalised: exponent and table fraction
          busy <= 1'b0;
          done <= 1'b1;
          res  <= {e, LOG_TAB[log_index(m)]};
        end else begin
          m <= {m[14:0], 1'b0};
          e <= e - 4'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/eae_checker.sv @@
// ----------------------------------------------------------------------------
// eae_checker - port-level checks for the envelope block
// Handshake, busy and result range checks, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module eae_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cmd_valid,
  input logic                        cmd_ready,
  input logic [eae_pkg::MODE_W-1:0]  cmd_mode,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [eae_pkg::LEVEL_W-1:0] rsp_level,
  input logic [eae_pkg::STAGE_W-1:0] rsp_stage
);
  import eae_pkg::*;

  // ready straight after reset
  a_ready_after_reset: assert property (@(posedge clk) $past(rst) |-> cmd_ready)
    else $error("command channel not ready after reset");

  // a real command makes the block busy
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && cmd_mode != MODE_UNUSED) |=> !cmd_ready)
    else $error("command accepted back to back");

  // stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_level) && $stable(rsp_stage)))
    else $error("stalled result word changed");

  // result in range; off stage always reports zero
  a_rsp_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_level <= 16'd32768 && rsp_stage <= ST_RELEASE &&
                   (rsp_stage != ST_OFF || rsp_level == 16'd0)))
    else $error("result word out of range");

endmodule

bind exponential_adsr_envelope eae_checker u_eae_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .cmd_mode  (cmd.mode),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_level (rsp.level),
  .rsp_stage (rsp.stage)
);

`default_nettype wire

@@ tb/eae_envelope_checker.sv @@
// ----------------------------------------------------------------------------
// eae_envelope_checker - envelope predictor and result scoreboard
// Tracks register writes on the APB port, runs its own fixed-point model of
// the envelope on every accepted command word and compares each accepted
// result word with the oldest predicted level and stage.
// ----------------------------------------------------------------------------
`default_nettype none

module eae_envelope_checker
  import eae_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  eae_cmd_if                  cmd,
  eae_rsp_if                  rsp,
  output int                  pending,
  output int                  errors
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [STAGE_W-1:0] stage;
  } env_word_t;

  env_word_t   env_expected_q[$];
  logic [15:0] log2_frac [LOG_TABLE_ENTRIES];

  // register copies
  logic [23:0] atk_len, dec_len, rel_len;
  logic [15:0] atk_lvl, sus_lvl, min_lvl, vel_sense;

  // envelope state
  logic [STAGE_W-1:0] env_stage;
  logic [31:0]        env_level, env_mult;
  logic [CNT_W-1:0]   env_count, env_len;

  // log2(1 + i/N) fractions by repeated squaring
  initial begin
    logic [63:0] y;
    logic [15:0] r;
    for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
      y = (64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_ENTRIES);
      r = '0;
      for (int b = 0; b < 16; b++) begin
        y = (y * y) >> 30;
        r = r << 1;
        if (y >= (64'd1 << 31)) begin
          y = y >> 1;
          r = r | 16'd1;
        end
      end
      log2_frac[i] = r;
    end
  end

  // log2 of a raw level in Q16.16
  function automatic longint level_log2(longint unsigned x);
    longint unsigned e, m, idx;
    if (x == 0) x = 1;
    if (x > 65535) x = 65535;
    e = 0;
    while (e < 15 && (x >> (e + 1)) != 0) e++;
    m = x << (15 - e);
    idx = ((m - 32768) * LOG_TABLE_ENTRIES) >> 15;
    if (idx >= LOG_TABLE_ENTRIES) idx = LOG_TABLE_ENTRIES - 1;
    return longint'(e) * 65536 + longint'(log2_frac[idx]);
  endfunction

  // per-sample multiplier 1 + ln(end/start)/len in Q30
  function automatic logic [31:0] stage_mult(longint unsigned from_lvl,
                                             longint unsigned to_lvl,
                                             longint unsigned len);
    longint          lnq;
    longint unsigned mag, q, r;
    if (len == 0) return ONE_Q30;
    lnq = (level_log2(to_lvl) - level_log2(from_lvl)) * longint'(LN2_Q16);
    mag = lnq < 0 ? longint'(-lnq) : lnq;
    q = (mag + 2 * len) / (4 * len);
    if (lnq < 0) return q >= 64'(ONE_Q30) ? 32'd0 : 32'(64'(ONE_Q30) - q);
    r = 64'(ONE_Q30) + q;
    return r > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : r[31:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_len(logic [23:0] v);
    return 64'(v) > 64'(COUNT_MAX) ? COUNT_MAX[CNT_W-1:0] : CNT_W'(v);
  endfunction

  function automatic void enter_stage(logic [STAGE_W-1:0] s);
    longint unsigned floor_lvl, from_lvl, to_lvl, cur;
    floor_lvl = min_lvl != 0 ? min_lvl : 1;
    env_stage = s;
    env_count = '0;
    case (s)
      ST_ATTACK: begin
        env_len   = sat_len(atk_len);
        env_level = 32'(floor_lvl << 15);
        env_mult  = stage_mult(floor_lvl, atk_lvl != 0 ? atk_lvl : 1, env_len);
      end
      ST_DECAY: begin
        env_len   = sat_len(dec_len);
        from_lvl  = atk_lvl < floor_lvl ? floor_lvl : atk_lvl;
        to_lvl    = sus_lvl > floor_lvl ? sus_lvl : floor_lvl;
        env_level = 32'(from_lvl << 15);
        env_mult  = stage_mult(from_lvl, to_lvl, env_len);
      end
      ST_SUSTAIN: begin
        env_level = 32'(64'(sus_lvl) << 15);
        env_mult  = ONE_Q30;
      end
      ST_RELEASE: begin
        env_len = sat_len(rel_len);
        cur = env_level >> 15;
        if (cur > 65535) cur = 65535;
        // a start below the floor is lifted to it
        if (cur < floor_lvl) begin
          cur       = floor_lvl;
          env_level = 32'(floor_lvl << 15);
        end
        env_mult = stage_mult(cur, floor_lvl, env_len);
      end
      default: begin
        env_stage = ST_OFF;
        env_level = '0;
        env_mult  = ONE_Q30;
      end
    endcase
  endfunction

  // one tick: returns the expected result word
  function automatic env_word_t tick_result(logic [15:0] vel);
    env_word_t       w;
    longint unsigned p, lv;
    longint          scale;
    if (env_stage == ST_OFF) begin
      lv = env_level >> 15;
      w.level = lv > 32768 ? 16'd32768 : 16'(lv);
      w.stage = ST_OFF;
      return w;
    end
    if (env_stage != ST_SUSTAIN) begin
      if (64'(env_count) >= 64'(env_len))
        enter_stage(env_stage == ST_RELEASE ? ST_OFF : env_stage + 3'd1);
      p = 64'(env_level) * 64'(env_mult) + (64'd1 << 29);
      p = p >> 30;
      env_level = p > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : p[31:0];
      env_count = env_count + 1'b1;
    end
    scale = longint'(vel_sense) * longint'(vel)
          + (32768 - longint'(vel_sense)) * 32768;
    if (scale < 0) scale = 0;
    lv = (64'(env_level) * 64'(scale)) >> 45;
    w.level = lv > 32768 ? 16'd32768 : 16'(lv);
    w.stage = env_stage;
    return w;
  endfunction

  task automatic report(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    env_word_t w;
    if (rst) begin
      atk_len = 24'd480;   dec_len = 24'd4800;   rel_len = 24'd4800;
      atk_lvl = 16'd32768; sus_lvl = 16'd16384;  min_lvl = 16'd33;
      vel_sense = 16'd0;
      env_stage = ST_OFF;  env_level = '0;       env_mult = ONE_Q30;
      env_count = '0;      env_len = '0;
      errors = 0;
      env_expected_q.delete();
    end else begin
      // register write
      if (psel && penable && pwrite && pready) begin
        case (3'(paddr >> 2))
          REG_ATTACK_SAMPLES:  atk_len   = pwdata[23:0];
          REG_DECAY_SAMPLES:   dec_len   = pwdata[23:0];
          REG_RELEASE_SAMPLES: rel_len   = pwdata[23:0];
          REG_ATTACK_LEVEL:    atk_lvl   = pwdata[15:0];
          REG_SUSTAIN_LEVEL:   sus_lvl   = pwdata[15:0];
          REG_MIN_LEVEL:       min_lvl   = pwdata[15:0];
          REG_VELOCITY_SENSE:  vel_sense = pwdata[15:0];
          default: ;
        endcase
      end
      // result word against oldest prediction
      if (rsp.valid && rsp.ready) begin
        if (env_expected_q.size() == 0) begin
          report("unexpected word level", int'(rsp.level), -1);
        end else begin
          w = env_expected_q.pop_front();
          if (rsp.level !== w.level) report("level", int'(rsp.level), int'(w.level));
          if (rsp.stage !== w.stage) report("stage", int'(rsp.stage), int'(w.stage));
        end
      end
      // command word
      if (cmd.valid && cmd.ready) begin
        case (cmd.mode)
          MODE_TICK:    env_expected_q.push_back(tick_result(cmd.velocity));
          MODE_NOTE_ON: enter_stage(ST_ATTACK);
          MODE_RELEASE: enter_stage(ST_RELEASE);
          default: ;
        endcase
      end
    end
    pending = env_expected_q.size();
  end

endmodule

`default_nettype wire

@@ tb/tb_exponential_adsr_envelope.sv @@
// ----------------------------------------------------------------------------
// tb_exponential_adsr_envelope - top of the envelope testbench
// Drives reset, register writes and command words with bursty timing and a
// stalling result receiver; the checker beside the block predicts and
// compares, and this top gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_exponential_adsr_envelope;
  import eae_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE      = 300;

  logic               clk, rst;
  logic               psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata, prdata;
  int                 pending, errors, cycles;
  int                 burst_left;
  int                 stall_left, free_run;

  eae_cmd_if cmd ();
  eae_rsp_if rsp ();

  exponential_adsr_envelope dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cmd(cmd.sink), .rsp(rsp.source)
  );

  eae_envelope_checker u_checker (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .cmd, .rsp, .pending, .errors
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run-away guard
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: long free-running stretches, else random and burst stalls
  initial begin
    rsp.ready  = 1'b0;
    stall_left = 0;
    free_run   = 0;
  end
  always @(negedge clk) begin
    if (free_run > 0) begin
      free_run   <= free_run - 1;
      rsp.ready  <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp.ready  <= 1'b0;
    end else begin
      case ($urandom_range(0, 99))
        0:       free_run   <= $urandom_range(100, 600);
        1, 2:    stall_left <= $urandom_range(5, 40);
        default: ;
      endcase
      rsp.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 2; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // lower valid, wait for all results, then let the block finish silently
  task automatic drain();
    @(negedge clk);
    cmd.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic configure(logic [23:0] al, dl, rl, logic [15:0] atl, sl, ml, vs);
    drain();
    reg_write(REG_ATTACK_SAMPLES, 32'(al));
    reg_write(REG_DECAY_SAMPLES, 32'(dl));
    reg_write(REG_RELEASE_SAMPLES, 32'(rl));
    reg_write(REG_ATTACK_LEVEL, 32'(atl));
    reg_write(REG_SUSTAIN_LEVEL, 32'(sl));
    reg_write(REG_MIN_LEVEL, 32'(ml));
    reg_write(REG_VELOCITY_SENSE, 32'(vs));
  endtask

  // one command word; valid stays high after acceptance for the next one
  task automatic send(logic [MODE_W-1:0] m, logic [15:0] v);
    cmd.valid <= 1'b1; cmd.mode <= m; cmd.velocity <= v;
    #1;
    while (!cmd.ready) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
  endtask

  // bursty sender: gaps between bursts of random length
  task automatic send_bursty(logic [MODE_W-1:0] m, logic [15:0] v);
    if (burst_left == 0) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 9) == 0) burst_left = 0;
    end
    send(m, v);
    if (burst_left > 0) burst_left--;
  endtask

  function automatic logic [15:0] rand_vel();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'd32768;
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [23:0] rand_len();
    case ($urandom_range(0, 19))
      0:       return 24'd0;
      1:       return 24'($urandom_range(100, 400));
      default: return 24'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [15:0] rand_lvl(int lo);
    case ($urandom_range(0, 7))
      0:       return 16'(lo);
      1:       return 16'd32768;
      default: return 16'($urandom_range(lo, 32768));
    endcase
  endfunction

  // note sequences with random content, plus some noise
  task automatic random_phase(int n);
    int done;
    int r;
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      if (r < 8)       send_bursty(MODE_NOTE_ON, rand_vel());
      else if (r < 15) send_bursty(MODE_RELEASE, rand_vel());
      else if (r < 18) send_bursty(MODE_UNUSED, rand_vel());
      else             send_bursty(MODE_TICK, rand_vel());
      if (r >= 15 && r < 18) continue;
      done++;
      if (done == n / 2 && $urandom_range(0, 1) == 0) begin
        // hold off until every result has come
        @(negedge clk);
        cmd.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cmd.valid = 1'b0; cmd.mode = MODE_TICK; cmd.velocity = '0;
    burst_left = 0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // off after reset, then release from off runs flat at the floor
    send(MODE_TICK, 16'd32768);
    send(MODE_RELEASE, 16'd0);
    send(MODE_TICK, 16'd0);
    send(MODE_TICK, 16'd32768);

    // short stages, full velocity response
    configure(24'd3, 24'd0, 24'd2, 16'd32768, 16'd0, 16'd1, 16'd32768);
    send(MODE_NOTE_ON, 16'd0);
    repeat (6) send(MODE_TICK, 16'd32768);
    send(MODE_UNUSED, 16'hFFFF);
    send(MODE_TICK, 16'd0);
    send(MODE_RELEASE, 16'd0);
    send(MODE_RELEASE, 16'd0);
    repeat (4) send(MODE_TICK, 16'd16384);

    // zero levels treated as one, lengths at the counter maximum
    configure(24'hFFFFFF, 24'd5, 24'hFFFFFF, 16'd0, 16'd32768, 16'd0, 16'd0);
    send(MODE_NOTE_ON, 16'd0);
    repeat (3) send(MODE_TICK, 16'd32768);
    send(MODE_RELEASE, 16'd0);
    send(MODE_TICK, 16'd32768);

    // floor above attack and sustain levels
    configure(24'd2, 24'd2, 24'd2, 16'd100, 16'd50, 16'd32768, 16'd20000);
    random_phase(60);

    // the reset defaults with velocity response
    configure(24'd480, 24'd4800, 24'd4800, 16'd32768, 16'd16384, 16'd33, 16'd32768);
    random_phase(40);

    for (int ph = 0; ph < 5; ph++) begin
      configure(rand_len(), rand_len(), rand_len(), rand_lvl(1), rand_lvl(0),
                16'($urandom_range(1, 2000)), rand_lvl(0));
      random_phase(130);
    end

    drain();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
sv/eae_pkg.sv
sv/eae_stream_if.sv
sv/eae_mul.sv
sv/eae_div.sv
sv/eae_log2.sv
sv/exponential_adsr_envelope.sv
sv/eae_checker.sv
tb/eae_envelope_checker.sv
tb/tb_exponential_adsr_envelope.sv
